>>> src/median_filter_3x3_macros.svh
// assertion macros shared by the median filter modules
// no dependencies; included by the files that carry assertions
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MF3_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define MF3_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/mf3_pkg.sv
// shared types and constants of the 3x3 median filter
// no dependencies; imported by every module of the block
package mf3_pkg;

   // default sizing of the line stores and frame counters
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   // field widths
   localparam int PIXEL_W      = 8;
   localparam int COL_OUT_W    = 10;
   localparam int ROW_OUT_W    = 12;
   localparam int IMG_WIDTH_W  = 11;
   localparam int IMG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;

   // register defaults and lower limit of both dimensions
   localparam int IMG_WIDTH_RESET  = 512;
   localparam int IMG_HEIGHT_RESET = 512;
   localparam int MIN_DIM          = 3;

   // register indexes
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // position and flags that travel with a pixel down the pipeline
   typedef struct packed {
      logic                 emit;
      logic                 last;
      logic [COL_OUT_W-1:0] center_col;
      logic [ROW_OUT_W-1:0] center_row;
   } pos_meta_type;

   // line store control for one accepted pixel
   typedef struct packed {
      logic         row_ge1;
      logic         row_ge2;
      pos_meta_type meta;
   } lb_ctl_type;

   // one window column, top row first
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] bot;
   } column_type;

endpackage

>>> src/mf3_line_buf.sv
// two line stores in synchronous memories with read-modify-write and forwarding
// depends on mf3_pkg and median_filter_3x3_macros.svh
`include "median_filter_3x3_macros.svh"

module mf3_line_buf #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [$clog2(MAX_WIDTH)-1:0]  in_addr,
   input  logic [mf3_pkg::PIXEL_W-1:0]   in_pixel,
   input  mf3_pkg::lb_ctl_type           in_ctl,
   output logic                          out_valid,
   input  logic                          out_ready,
   output mf3_pkg::column_type           out_column,
   output mf3_pkg::pos_meta_type         out_meta
);
   import mf3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic [PIXEL_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIXEL_W-1:0] middle_mem [MAX_WIDTH];

   logic [PIXEL_W-1:0] rd_upper_ff;
   logic [PIXEL_W-1:0] rd_middle_ff;

   logic               s1_valid_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   lb_ctl_type         s1_ctl_ff;
   logic               s1_fwd_ff;
   logic [PIXEL_W-1:0] fwd_upper_ff;
   logic [PIXEL_W-1:0] fwd_middle_ff;

   logic               s2_valid_ff;
   column_type         s2_column_ff;
   pos_meta_type       s2_meta_ff;

   logic               accept;
   logic               s1_free;
   logic               s2_free;
   logic               s1_adv;
   logic               fwd_hit;
   logic [PIXEL_W-1:0] eff_upper;
   logic [PIXEL_W-1:0] eff_middle;
   logic [PIXEL_W-1:0] new_upper;
   column_type         column_in;

   // flow control
   assign s2_free  = !s2_valid_ff || out_ready;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign in_ready = s1_free;
   assign accept   = in_valid && s1_free;

   // a new read of the entry written back in the same cycle takes the write data
   assign fwd_hit = accept && s1_valid_ff && (s1_addr_ff == in_addr);

   // effective contents of the entry, from memory or from the write just done
   always_comb begin
      eff_upper  = s1_fwd_ff ? fwd_upper_ff  : rd_upper_ff;
      eff_middle = s1_fwd_ff ? fwd_middle_ff : rd_middle_ff;
      new_upper  = s1_ctl_ff.row_ge1 ? eff_middle : eff_upper;
      column_in.top = s1_ctl_ff.row_ge2 ? eff_upper  : '0;
      column_in.mid = s1_ctl_ff.row_ge2 ? eff_middle : '0;
      column_in.bot = s1_pixel_ff;
   end

   // line store memories: read on accept, write back as the pixel leaves stage 1
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_upper_ff  <= upper_mem[in_addr];
         rd_middle_ff <= middle_mem[in_addr];
      end
      if (s1_adv) begin
         middle_mem[s1_addr_ff] <= s1_pixel_ff;
         if (s1_ctl_ff.row_ge1) begin
            upper_mem[s1_addr_ff] <= eff_middle;
         end
      end
   end

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= in_valid;
         s1_fwd_ff   <= fwd_hit;
      end
   end

   // stage 1 payload and forwarded entry
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff    <= in_addr;
         s1_pixel_ff   <= in_pixel;
         s1_ctl_ff     <= in_ctl;
         fwd_upper_ff  <= new_upper;
         fwd_middle_ff <= s1_pixel_ff;
      end
   end

   // stage 2: the new window column
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_column_ff <= column_in;
         s2_meta_ff   <= s1_ctl_ff.meta;
      end
   end

   assign out_valid  = s2_valid_ff;
   assign out_column = s2_column_ff;
   assign out_meta   = s2_meta_ff;

   // forwarding only ever follows a pixel at the same column
   `MF3_ASSERT_IMP(a_fwd_same_addr, clock, reset, s1_fwd_ff, s1_addr_ff == $past(s1_addr_ff), "forward flag set for a different column")
   // a stalled stage 1 keeps its pixel and column
   `MF3_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !s2_free, s1_valid_ff && $stable(s1_addr_ff), "stage 1 lost its pixel under stall")

endmodule

>>> src/mf3_median.sv
// sliding window of sorted columns and pipelined median of nine
// depends on mf3_pkg and median_filter_3x3_macros.svh
`include "median_filter_3x3_macros.svh"

module mf3_median (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  mf3_pkg::column_type          in_column,
   input  mf3_pkg::pos_meta_type        in_meta,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [mf3_pkg::PIXEL_W-1:0]  out_median,
   output mf3_pkg::pos_meta_type        out_meta
);
   import mf3_pkg::*;

   function automatic logic [PIXEL_W-1:0] min3(input logic [PIXEL_W-1:0] a,
                                               input logic [PIXEL_W-1:0] b,
                                               input logic [PIXEL_W-1:0] c);
      logic [PIXEL_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic [PIXEL_W-1:0] max3(input logic [PIXEL_W-1:0] a,
                                               input logic [PIXEL_W-1:0] b,
                                               input logic [PIXEL_W-1:0] c);
      logic [PIXEL_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic [PIXEL_W-1:0] med3(input logic [PIXEL_W-1:0] a,
                                               input logic [PIXEL_W-1:0] b,
                                               input logic [PIXEL_W-1:0] c);
      logic [PIXEL_W-1:0] lo;
      logic [PIXEL_W-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) begin
         return lo;
      end else if (c >= hi) begin
         return hi;
      end
      return c;
   endfunction

   // window of sorted columns, index 2 newest
   logic [PIXEL_W-1:0] win_lo_ff [3];
   logic [PIXEL_W-1:0] win_md_ff [3];
   logic [PIXEL_W-1:0] win_hi_ff [3];
   logic               s3_valid_ff;
   pos_meta_type       s3_meta_ff;

   logic               s4_valid_ff;
   logic [PIXEL_W-1:0] cand_lo_ff;
   logic [PIXEL_W-1:0] cand_md_ff;
   logic [PIXEL_W-1:0] cand_hi_ff;
   pos_meta_type       s4_meta_ff;

   logic               out_valid_ff;
   logic [PIXEL_W-1:0] out_median_ff;
   pos_meta_type       out_meta_ff;

   logic               out_free;
   logic               s4_free;
   logic               s3_free;
   logic               load_win;
   logic               load_s4;

   // flow control; pixels with no result are dropped after the window
   assign out_free = !out_valid_ff || out_ready;
   assign s4_free  = !s4_valid_ff || out_free;
   assign s3_free  = !s3_valid_ff || !s3_meta_ff.emit || s4_free;
   assign in_ready = s3_free;
   assign load_win = in_valid && s3_free;
   assign load_s4  = s4_free && s3_valid_ff && s3_meta_ff.emit;

   // stage 3: sort the new column and shift it into the window
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_win) begin
         win_lo_ff[0] <= win_lo_ff[1];
         win_lo_ff[1] <= win_lo_ff[2];
         win_lo_ff[2] <= min3(in_column.top, in_column.mid, in_column.bot);
         win_md_ff[0] <= win_md_ff[1];
         win_md_ff[1] <= win_md_ff[2];
         win_md_ff[2] <= med3(in_column.top, in_column.mid, in_column.bot);
         win_hi_ff[0] <= win_hi_ff[1];
         win_hi_ff[1] <= win_hi_ff[2];
         win_hi_ff[2] <= max3(in_column.top, in_column.mid, in_column.bot);
         s3_meta_ff   <= in_meta;
      end
   end

   // stage 4: largest low, middle median, smallest high
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_free) begin
         s4_valid_ff <= s3_valid_ff && s3_meta_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s4) begin
         cand_lo_ff <= max3(win_lo_ff[0], win_lo_ff[1], win_lo_ff[2]);
         cand_md_ff <= med3(win_md_ff[0], win_md_ff[1], win_md_ff[2]);
         cand_hi_ff <= min3(win_hi_ff[0], win_hi_ff[1], win_hi_ff[2]);
         s4_meta_ff <= s3_meta_ff;
      end
   end

   // output register: median of the three candidates
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s4_valid_ff) begin
         out_median_ff <= med3(cand_lo_ff, cand_md_ff, cand_hi_ff);
         out_meta_ff   <= s4_meta_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_median = out_median_ff;
   assign out_meta   = out_meta_ff;

   // only pixels with a full interior window reach the last two stages
   `MF3_ASSERT_IMP(a_s4_emit, clock, reset, s4_valid_ff, s4_meta_ff.emit, "stage 4 holds a pixel without a result")
   `MF3_ASSERT_IMP(a_out_emit, clock, reset, out_valid_ff, out_meta_ff.emit, "result beat for a border pixel")

endmodule

>>> src/median_filter_3x3.sv
// top level of the 3x3 median filter: registers, frame counters and the pipeline
// depends on mf3_pkg, mf3_line_buf, mf3_median and median_filter_3x3_macros.svh
//
// Usage: pixels of a grayscale frame enter in raster order on the req_ channel,
// one beat per pixel; req_frame_start marks row 0, column 0 of a new frame, and a
// frame also restarts by itself after its last pixel. Each interior pixel (not on
// the first or last row or column) gets one beat on the rsp_ channel carrying
// the median of its 3x3 neighbourhood, its column and row, and rsp_last on the
// final interior pixel of the frame. Border pixels give no beat.
// The beat for a centre pixel leaves once the pixel one row below and one column
// to the right is taken; its result passes stages 1, 2, 3 and 4 and the output
// register. One pixel is taken every cycle unless the pipeline stalls: the line
// stores are two single-port-read memories, read once per pixel and written back
// as it leaves stage 1, with forwarding when successive pixels hit the same column.
// The csr_ channel (always ready) writes image_width and image_height, clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT; write them only while the filter is idle.
// Reset: both dimensions return to 512 and the counters to row 0, column 0; no
// clearing pass is needed. When rsp_ready is low the pipeline fills and then
// req_ready falls; nothing is dropped.
`include "median_filter_3x3_macros.svh"

module median_filter_3x3 #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mf3_pkg::PIXEL_W-1:0]    req_pixel,
   input  logic                           req_frame_start,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mf3_pkg::PIXEL_W-1:0]    rsp_median,
   output logic [mf3_pkg::COL_OUT_W-1:0]  rsp_center_col,
   output logic [mf3_pkg::ROW_OUT_W-1:0]  rsp_center_row,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  mf3_pkg::csr_index_type         csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0] csr_data
);
   import mf3_pkg::*;

   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int RW        = $clog2(MAX_HEIGHT);
   localparam int WW        = $clog2(MAX_WIDTH + 1);
   localparam int HW        = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W    = (WW > IMG_WIDTH_W) ? WW : IMG_WIDTH_W;
   localparam int HCMP_W    = (HW > IMG_HEIGHT_W) ? HW : IMG_HEIGHT_W;
   localparam int WIDTH_RST = (IMG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMG_WIDTH_RESET;
   localparam int HEIGHT_RST =
      (IMG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMG_HEIGHT_RESET;

   logic [WW-1:0]     width_ff;
   logic [HW-1:0]     height_ff;
   logic [WCMP_W-1:0] width_raw;
   logic [HCMP_W-1:0] height_raw;
   logic [WW-1:0]     width_clamp;
   logic [HW-1:0]     height_clamp;

   logic [CW-1:0]     col_ff;
   logic [RW-1:0]     row_ff;
   logic [CW-1:0]     col_in;
   logic [RW-1:0]     row_in;
   logic [CW-1:0]     col_cur;
   logic [RW-1:0]     row_cur;
   logic [CW-1:0]     col_m1;
   logic [RW-1:0]     row_m1;
   logic [CW:0]       col_inc;
   logic [RW:0]       row_inc;
   logic              col_wrap;
   logic              row_wrap;
   logic              accept;
   lb_ctl_type        ctl;

   logic              lb_valid;
   logic              lb_ready;
   column_type        lb_column;
   pos_meta_type      lb_meta;
   pos_meta_type      rsp_meta;

   // register writes, clamped to the legal range
   assign csr_ready = 1'b1;

   always_comb begin
      width_raw  = WCMP_W'(csr_data[IMG_WIDTH_W-1:0]);
      height_raw = HCMP_W'(csr_data[IMG_HEIGHT_W-1:0]);
      if (width_raw < WCMP_W'(MIN_DIM)) begin
         width_clamp = WW'(MIN_DIM);
      end else if (width_raw > WCMP_W'(MAX_WIDTH)) begin
         width_clamp = WW'(MAX_WIDTH);
      end else begin
         width_clamp = WW'(width_raw);
      end
      if (height_raw < HCMP_W'(MIN_DIM)) begin
         height_clamp = HW'(MIN_DIM);
      end else if (height_raw > HCMP_W'(MAX_HEIGHT)) begin
         height_clamp = HW'(MAX_HEIGHT);
      end else begin
         height_clamp = HW'(height_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(WIDTH_RST);
         height_ff <= HW'(HEIGHT_RST);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= width_clamp;
            CSR_IMAGE_HEIGHT: height_ff <= height_clamp;
         endcase
      end
   end

   // raster position of the incoming pixel and its successor
   assign accept = req_valid && req_ready;

   always_comb begin
      col_cur  = req_frame_start ? '0 : col_ff;
      row_cur  = req_frame_start ? '0 : row_ff;
      col_m1   = col_cur - CW'(1);
      row_m1   = row_cur - RW'(1);
      col_inc  = {1'b0, col_cur} + (CW + 1)'(1);
      row_inc  = {1'b0, row_cur} + (RW + 1)'(1);
      col_wrap = col_inc >= (CW + 1)'(width_ff);
      row_wrap = row_inc >= (RW + 1)'(height_ff);
      col_in   = col_wrap ? '0 : col_inc[CW-1:0];
      if (col_wrap) begin
         row_in = row_wrap ? '0 : row_inc[RW-1:0];
      end else begin
         row_in = row_cur;
      end

      ctl.row_ge1         = row_cur != '0;
      ctl.row_ge2         = row_cur >= RW'(2);
      ctl.meta.emit       = ctl.row_ge2 && (col_cur >= CW'(2)) &&
                            (HW'(row_cur) < height_ff) && (WW'(col_cur) < width_ff);
      ctl.meta.last       = (HW'(row_cur) == height_ff - HW'(1)) &&
                            (WW'(col_cur) == width_ff - WW'(1));
      ctl.meta.center_col = COL_OUT_W'(col_m1);
      ctl.meta.center_row = ROW_OUT_W'(row_m1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores and window column
   mf3_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_addr    (col_cur),
      .in_pixel   (req_pixel),
      .in_ctl     (ctl),
      .out_valid  (lb_valid),
      .out_ready  (lb_ready),
      .out_column (lb_column),
      .out_meta   (lb_meta)
   );

   // window and median
   mf3_median u_median (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (lb_valid),
      .in_ready   (lb_ready),
      .in_column  (lb_column),
      .in_meta    (lb_meta),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_median (rsp_median),
      .out_meta   (rsp_meta)
   );

   assign rsp_center_col = rsp_meta.center_col;
   assign rsp_center_row = rsp_meta.center_row;
   assign rsp_last       = rsp_meta.last;

   // within a row the column counter steps by one
   `MF3_ASSERT_NXT(a_col_step, clock, reset, accept && !req_frame_start && !col_wrap, col_ff == $past(col_ff) + CW'(1), "column counter skipped")

endmodule
